// File: rtl/gbn_pkg.sv
// package: shared constants, register codes and result type for the go-back-n sender
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int GBN_MAX_WINDOW = 64;
  localparam int GBN_SEQ_BITS   = 16;
  localparam int GBN_TIME_BITS  = 32;

  localparam int WINDOW_W   = 7;
  localparam int TIMEOUT_W  = 32;
  localparam int INTERVAL_W = 16;
  localparam int PKT_W      = 16;
  localparam int SEQ_W      = 16;
  localparam int BYTES_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int BYTE_SHIFT = 3;
  localparam int PKT_BYTES_W = PKT_W - BYTE_SHIFT;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET   = 2'd3;

  localparam logic [WINDOW_W-1:0]   WINDOW_RST   = 7'd8;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 32'd1000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd10;
  localparam logic [PKT_W-1:0]      PACKET_RST   = 16'd1024;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_ACK  = 1'b1;

  typedef struct packed {
    logic               send_valid;
    logic [SEQ_W-1:0]   send_seq;
    logic               timeout_fired;
    logic               reject_seen;
    logic               ack_accepted;
    logic               ack_ignored;
    logic [SEQ_W-1:0]   base_seq;
    logic [SEQ_W-1:0]   next_seq;
    logic [BYTES_W-1:0] sent_bytes;
    logic [BYTES_W-1:0] acked_bytes;
  } result_t;

endpackage

// File: rtl/go_back_n_arq_sender_unit.sv
// go-back-n arq sender window engine with output skid stage
//
//  channel  signals                                  direction
//  in       in_valid in_ready func ack_expected_seq  request in
//           ack_bit_error
//  out      out_valid out_ready send_valid ... acked_bytes  request out
//  cfg      cfg_valid cfg_ready cfg_index cfg_data   register write in
//
// one request per cycle while in_ready is high; state updates in the cycle a
// request is taken; the result is registered in the output or skid register.
// an ack that slides the base short of next_sequence reads the slot deadline
// memory; the registered read data goes into the timer on the next request.
// a two-entry output stage (result register and skid register) keeps in_ready
// high while one result waits; in_ready drops only when both are full.
// synchronous active-high reset; the slot memory has no reset.
`timescale 1ns / 1ps

module go_back_n_arq_sender_unit import gbn_pkg::*; #(
  parameter int MAX_WINDOW = GBN_MAX_WINDOW,
  parameter int SEQ_BITS   = GBN_SEQ_BITS,
  parameter int TIME_BITS  = GBN_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [SEQ_W-1:0]      ack_expected_seq,
  input  logic                  ack_bit_error,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  send_valid,
  output logic [SEQ_W-1:0]      send_seq,
  output logic                  timeout_fired,
  output logic                  reject_seen,
  output logic                  ack_accepted,
  output logic                  ack_ignored,
  output logic [SEQ_W-1:0]      base_seq,
  output logic [SEQ_W-1:0]      next_seq,
  output logic [BYTES_W-1:0]    sent_bytes,
  output logic [BYTES_W-1:0]    acked_bytes,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SLOTS     = 1 << SLOT_BITS;
  localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_A     = (SEQ_BITS > WIN_BITS) ? SEQ_BITS : WIN_BITS;
  localparam int CMP_BITS  = (CMP_A > WINDOW_W) ? CMP_A : WINDOW_W;

  // configuration
  logic [WINDOW_W-1:0]   window_size;
  logic [TIMEOUT_W-1:0]  timeout_ticks;
  logic [INTERVAL_W-1:0] interval_ticks;
  logic [PKT_W-1:0]      packet_bits;

  // window state
  logic [SEQ_BITS-1:0]  base_sequence, base_sequence_next;
  logic [SEQ_BITS-1:0]  next_sequence, next_sequence_next;
  logic [TIME_BITS-1:0] current_time, current_time_next;
  logic [TIME_BITS-1:0] send_due_time, send_due_time_next;
  logic                 send_armed, send_armed_next;
  logic [TIME_BITS-1:0] expiry_time, expiry_time_next;
  logic                 expiry_armed, expiry_armed_next;
  logic                 expiry_pending, expiry_pending_next;
  logic [BYTES_W-1:0]   bytes_sent_total, bytes_sent_total_next;
  logic [BYTES_W-1:0]   bytes_acked_total, bytes_acked_total_next;

  // slot deadline memory
  logic [TIME_BITS-1:0] slot_mem [SLOTS];
  logic [TIME_BITS-1:0] slot_q;
  logic                 mem_we, mem_re;
  logic [SLOT_BITS-1:0] mem_waddr, mem_raddr;

  // output stage
  result_t res, out_q, out_q_next, skid_q, skid_q_next;
  logic    out_full, out_full_next, skid_full, skid_full_next;

  logic take, drain;

  logic [CMP_BITS-1:0]    win_eff;
  logic [TIME_BITS-1:0]   to_step, iv_step, deadline, due_iv, exp_cur;
  logic [PKT_BYTES_W-1:0] pkt_bytes;
  logic [SEQ_BITS-1:0]    ack_seq, ack_dist, outstanding, next1, next2;
  logic                   fire, s_armed1, e_armed1;

  function automatic logic time_before(input logic [TIME_BITS-1:0] a,
                                       input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (a != b) && d[TIME_BITS-1];
  endfunction

  assign take      = in_valid && in_ready;
  assign drain     = out_full && out_ready;
  assign in_ready  = !skid_full;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (window_size == '0) begin
      win_eff = CMP_BITS'(1);
    end else if (CMP_BITS'(window_size) > CMP_BITS'(MAX_WINDOW)) begin
      win_eff = CMP_BITS'(MAX_WINDOW);
    end else begin
      win_eff = CMP_BITS'(window_size);
    end
  end

  assign to_step   = (timeout_ticks == '0) ? TIME_BITS'(1) : TIME_BITS'(timeout_ticks);
  assign iv_step   = (interval_ticks == '0) ? TIME_BITS'(1) : TIME_BITS'(interval_ticks);
  assign deadline  = current_time + to_step;
  assign due_iv    = current_time + iv_step;
  assign exp_cur   = expiry_pending ? slot_q : expiry_time;
  assign pkt_bytes = packet_bits[PKT_W-1:BYTE_SHIFT];
  assign ack_seq   = SEQ_BITS'(ack_expected_seq);
  assign ack_dist  = ack_seq - base_sequence;
  assign outstanding = next_sequence - base_sequence;

  always_comb begin
    base_sequence_next     = base_sequence;
    next_sequence_next     = next_sequence;
    current_time_next      = current_time;
    send_due_time_next     = send_due_time;
    send_armed_next        = send_armed;
    expiry_time_next       = exp_cur;
    expiry_armed_next      = expiry_armed;
    expiry_pending_next    = 1'b0;
    bytes_sent_total_next  = bytes_sent_total;
    bytes_acked_total_next = bytes_acked_total;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = next_sequence[SLOT_BITS-1:0];
    mem_raddr = ack_seq[SLOT_BITS-1:0];
    fire      = 1'b0;
    s_armed1  = send_armed;
    e_armed1  = expiry_armed;
    next1     = next_sequence;
    next2     = next_sequence;
    res       = '0;

    if (func == FUNC_TICK) begin
      // retransmission timer first
      fire = expiry_armed && (exp_cur == current_time);
      if (fire) begin
        if (!send_armed) begin
          send_due_time_next = current_time;
        end
        s_armed1 = 1'b1;
        e_armed1 = 1'b0;
        next1    = base_sequence;
      end
      send_armed_next    = s_armed1;
      expiry_armed_next  = e_armed1;
      next_sequence_next = next1;
      next2              = next1 + SEQ_BITS'(1);
      if ((packet_bits != '0) && s_armed1 && (send_due_time_next == current_time)) begin
        if (CMP_BITS'(next1 - base_sequence) >= win_eff) begin
          send_armed_next = 1'b0;
        end else begin
          res.send_valid        = 1'b1;
          res.send_seq          = SEQ_W'(next1);
          bytes_sent_total_next = bytes_sent_total + BYTES_W'(pkt_bytes);
          mem_we                = 1'b1;
          mem_waddr             = next1[SLOT_BITS-1:0];
          next_sequence_next    = next2;
          if (!e_armed1 || time_before(deadline, exp_cur)) begin
            expiry_time_next  = deadline;
            expiry_armed_next = 1'b1;
          end
          if (CMP_BITS'(next2 - base_sequence) >= win_eff) begin
            send_armed_next = 1'b0;
          end else begin
            send_due_time_next = due_iv;
          end
        end
      end
      res.timeout_fired = fire;
      current_time_next = current_time + TIME_BITS'(1);
    end else begin
      priority if (ack_bit_error) begin
        res.ack_ignored = 1'b1;
      end else if (ack_seq == base_sequence) begin
        res.reject_seen = 1'b1;
        if (!send_armed) begin
          send_armed_next    = 1'b1;
          send_due_time_next = current_time;
        end
        next_sequence_next = base_sequence;
      end else if (CMP_BITS'(ack_dist) > win_eff) begin
        res.ack_ignored = 1'b1;
      end else begin
        res.ack_accepted       = 1'b1;
        bytes_acked_total_next = bytes_acked_total
                               + BYTES_W'(BYTES_W'(pkt_bytes) * BYTES_W'(ack_dist));
        base_sequence_next     = ack_seq;
        if (outstanding > ack_dist) begin
          // timer rearmed from the new base slot, resolved next request
          mem_re              = 1'b1;
          expiry_pending_next = 1'b1;
          expiry_armed_next   = 1'b1;
        end else begin
          expiry_armed_next = 1'b0;
          if (outstanding < ack_dist) begin
            next_sequence_next = ack_seq;
          end
        end
        if (!send_armed) begin
          send_armed_next    = 1'b1;
          send_due_time_next = current_time;
        end
      end
    end

    res.base_seq    = SEQ_W'(base_sequence_next);
    res.next_seq    = SEQ_W'(next_sequence_next);
    res.sent_bytes  = bytes_sent_total_next;
    res.acked_bytes = bytes_acked_total_next;
  end

  always_ff @(posedge clk) begin
    if (take && mem_we) begin
      slot_mem[mem_waddr] <= deadline;
    end
    if (take && mem_re) begin
      slot_q <= slot_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= WINDOW_RST;
      timeout_ticks  <= TIMEOUT_RST;
      interval_ticks <= INTERVAL_RST;
      packet_bits    <= PACKET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW:   window_size    <= cfg_data[WINDOW_W-1:0];
        CFG_TIMEOUT:  timeout_ticks  <= cfg_data[TIMEOUT_W-1:0];
        CFG_INTERVAL: interval_ticks <= cfg_data[INTERVAL_W-1:0];
        CFG_PACKET:   packet_bits    <= cfg_data[PKT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_sequence     <= '0;
      next_sequence     <= '0;
      current_time      <= '0;
      send_due_time     <= '0;
      send_armed        <= 1'b1;
      expiry_time       <= '0;
      expiry_armed      <= 1'b0;
      expiry_pending    <= 1'b0;
      bytes_sent_total  <= '0;
      bytes_acked_total <= '0;
    end else if (take) begin
      base_sequence     <= base_sequence_next;
      next_sequence     <= next_sequence_next;
      current_time      <= current_time_next;
      send_due_time     <= send_due_time_next;
      send_armed        <= send_armed_next;
      expiry_time       <= expiry_time_next;
      expiry_armed      <= expiry_armed_next;
      expiry_pending    <= expiry_pending_next;
      bytes_sent_total  <= bytes_sent_total_next;
      bytes_acked_total <= bytes_acked_total_next;
    end
  end

  // output register and skid register
  always_comb begin
    out_q_next     = out_q;
    skid_q_next    = skid_q;
    out_full_next  = out_full;
    skid_full_next = skid_full;
    if (drain) begin
      if (skid_full) begin
        out_q_next     = skid_q;
        skid_full_next = 1'b0;
      end else begin
        out_full_next = 1'b0;
      end
    end
    if (take) begin
      if (!out_full_next) begin
        out_q_next    = res;
        out_full_next = 1'b1;
      end else begin
        skid_q_next    = res;
        skid_full_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_q  <= out_q_next;
    skid_q <= skid_q_next;
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      out_full  <= out_full_next;
      skid_full <= skid_full_next;
    end
  end

  assign out_valid     = out_full;
  assign send_valid    = out_q.send_valid;
  assign send_seq      = out_q.send_seq;
  assign timeout_fired = out_q.timeout_fired;
  assign reject_seen   = out_q.reject_seen;
  assign ack_accepted  = out_q.ack_accepted;
  assign ack_ignored   = out_q.ack_ignored;
  assign base_seq      = out_q.base_seq;
  assign next_seq      = out_q.next_seq;
  assign sent_bytes    = out_q.sent_bytes;
  assign acked_bytes   = out_q.acked_bytes;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench for the go-back-n sender unit: random paced requests, per-field result checks
module tb import gbn_pkg::*; ();

  localparam int TIME_W         = GBN_TIME_BITS;
  localparam int SLOT_BITS      = $clog2(GBN_MAX_WINDOW);
  localparam int N_PHASES       = 8;
  localparam int PHASE_REQS     = 92;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_LEN       = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINT      = 60;

  typedef struct packed {
    logic             func;
    logic [SEQ_W-1:0] ack_seq;
    logic             ack_err;
  } req_t;

  typedef struct packed {
    logic [WINDOW_W-1:0]             window;
    logic [TIMEOUT_W-1:0]            timeout;
    logic [INTERVAL_W-1:0]           interval;
    logic [PKT_W-1:0]                pkt_bits;
    logic [SEQ_W-1:0]                base;
    logic [SEQ_W-1:0]                next;
    logic [TIME_W-1:0]               now;
    logic [TIME_W-1:0]               send_due;
    logic                            send_armed;
    logic [TIME_W-1:0]               expiry;
    logic                            expiry_armed;
    logic [GBN_MAX_WINDOW-1:0][TIME_W-1:0] deadline;
    logic [BYTES_W-1:0]              sent;
    logic [BYTES_W-1:0]              acked;
  } window_state_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  func = FUNC_TICK;
  logic [SEQ_W-1:0]      ack_expected_seq = '0;
  logic                  ack_bit_error = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  send_valid;
  logic [SEQ_W-1:0]      send_seq;
  logic                  timeout_fired;
  logic                  reject_seen;
  logic                  ack_accepted;
  logic                  ack_ignored;
  logic [SEQ_W-1:0]      base_seq;
  logic [SEQ_W-1:0]      next_seq;
  logic [BYTES_W-1:0]    sent_bytes;
  logic [BYTES_W-1:0]    acked_bytes;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  window_state_t chk_st;
  window_state_t gen_st;
  req_t          pending_reqs[$];
  result_t       expected_results[$];
  req_t          offered;
  int unsigned   send_gap;
  int unsigned   recv_pause;
  int unsigned   pause_len;
  int            n_results;
  int            n_errors;
  int            stalled_cycles;
  bit            quiet;

  go_back_n_arq_sender_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .ack_expected_seq(ack_expected_seq),
    .ack_bit_error(ack_bit_error),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .send_valid(send_valid),
    .send_seq(send_seq),
    .timeout_fired(timeout_fired),
    .reject_seen(reject_seen),
    .ack_accepted(ack_accepted),
    .ack_ignored(ack_ignored),
    .base_seq(base_seq),
    .next_seq(next_seq),
    .sent_bytes(sent_bytes),
    .acked_bytes(acked_bytes),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [WINDOW_W-1:0] window_limit(input logic [WINDOW_W-1:0] w);
    if (w == 0) return WINDOW_W'(1);
    if (w > GBN_MAX_WINDOW) return WINDOW_W'(GBN_MAX_WINDOW);
    return w;
  endfunction

  function automatic void arm_send(inout window_state_t s);
    if (!s.send_armed) begin
      s.send_armed = 1'b1;
      s.send_due = s.now;
    end
  endfunction

  function automatic result_t window_step(inout window_state_t s, input req_t rq);
    result_t                r;
    logic [TIME_W-1:0]      t;
    logic [TIME_W-1:0]      dl;
    logic [TIME_W-1:0]      lead;
    logic [TIME_W-1:0]      to;
    logic [INTERVAL_W-1:0]  iv;
    logic [SEQ_W-1:0]       ahead;
    logic [SEQ_W-1:0]       span;
    logic [WINDOW_W-1:0]    w;
    logic [PKT_BYTES_W-1:0] pkt_bytes;
    r = '0;
    w = window_limit(s.window);
    pkt_bytes = s.pkt_bits[PKT_W-1:BYTE_SHIFT];
    if (rq.func == FUNC_TICK) begin
      t = s.now;
      if (s.expiry_armed && s.expiry == t) begin
        r.timeout_fired = 1'b1;
        arm_send(s);
        s.next = s.base;
        s.expiry_armed = 1'b0;
      end
      if (s.pkt_bits != 0 && s.send_armed && s.send_due == t) begin
        span = s.next - s.base;
        if (span >= w) begin
          s.send_armed = 1'b0;
        end else begin
          to = (s.timeout == 0) ? TIME_W'(1) : s.timeout;
          iv = (s.interval == 0) ? INTERVAL_W'(1) : s.interval;
          dl = t + to;
          r.send_valid = 1'b1;
          r.send_seq = s.next;
          s.sent = s.sent + pkt_bytes;
          s.deadline[s.next[SLOT_BITS-1:0]] = dl;
          s.next = s.next + 1'b1;
          // wrapping compare: new deadline strictly earlier than the armed one
          lead = dl - s.expiry;
          if (!s.expiry_armed || (dl != s.expiry && lead[TIME_W-1])) begin
            s.expiry = dl;
            s.expiry_armed = 1'b1;
          end
          span = s.next - s.base;
          if (span >= w) s.send_armed = 1'b0;
          else s.send_due = t + iv;
        end
      end
      s.now = t + 1'b1;
    end else if (rq.ack_err) begin
      r.ack_ignored = 1'b1;
    end else if (rq.ack_seq == s.base) begin
      r.reject_seen = 1'b1;
      arm_send(s);
      s.next = s.base;
    end else begin
      ahead = rq.ack_seq - s.base;
      if (ahead > w) begin
        r.ack_ignored = 1'b1;
      end else begin
        span = s.next - s.base;
        r.ack_accepted = 1'b1;
        s.acked = s.acked + pkt_bytes * ahead;
        s.base = rq.ack_seq;
        if (span > ahead) begin
          s.expiry = s.deadline[s.base[SLOT_BITS-1:0]];
          s.expiry_armed = 1'b1;
        end else begin
          s.expiry_armed = 1'b0;
          if (span < ahead) s.next = s.base;
        end
        arm_send(s);
      end
    end
    r.base_seq = s.base;
    r.next_seq = s.next;
    r.sent_bytes = s.sent;
    r.acked_bytes = s.acked;
    return r;
  endfunction

  function automatic void apply_reg(inout window_state_t s, input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_WINDOW:   s.window = data[WINDOW_W-1:0];
      CFG_TIMEOUT:  s.timeout = data[TIMEOUT_W-1:0];
      CFG_INTERVAL: s.interval = data[INTERVAL_W-1:0];
      CFG_PACKET:   s.pkt_bits = data[PKT_W-1:0];
      default:      ;
    endcase
  endfunction

  function automatic int unsigned draw_pause();
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic report(input string msg);
    if (n_errors < MAX_PRINT) $display("ERROR: %s", msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h", n_results, name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result %0d arrived with no request outstanding", n_results));
    end else begin
      want = expected_results.pop_front();
      check_field("send_valid", 32'(send_valid), 32'(want.send_valid));
      check_field("send_seq", 32'(send_seq), 32'(want.send_seq));
      check_field("timeout_fired", 32'(timeout_fired), 32'(want.timeout_fired));
      check_field("reject_seen", 32'(reject_seen), 32'(want.reject_seen));
      check_field("ack_accepted", 32'(ack_accepted), 32'(want.ack_accepted));
      check_field("ack_ignored", 32'(ack_ignored), 32'(want.ack_ignored));
      check_field("base_seq", 32'(base_seq), 32'(want.base_seq));
      check_field("next_seq", 32'(next_seq), 32'(want.next_seq));
      check_field("sent_bytes", sent_bytes, want.sent_bytes);
      check_field("acked_bytes", acked_bytes, want.acked_bytes);
    end
  endtask

  task automatic queue_req(input logic f, input logic [SEQ_W-1:0] seq, input logic err);
    req_t rq;
    rq.func = f;
    rq.ack_seq = seq;
    rq.ack_err = err;
    void'(window_step(gen_st, rq));
    pending_reqs.push_back(rq);
  endtask

  task automatic queue_random_req();
    int unsigned         pick;
    logic [WINDOW_W-1:0] w;
    pick = $urandom_range(0, 99);
    w = window_limit(gen_st.window);
    if (pick < 55)
      queue_req(FUNC_TICK, SEQ_W'($urandom), 1'($urandom));
    else if (pick < 85)
      queue_req(FUNC_ACK, SEQ_W'(gen_st.base + $urandom_range(0, w)),
                $urandom_range(0, 9) == 0);
    else if (pick < 90)
      queue_req(FUNC_ACK, SEQ_W'(gen_st.base + w + 1 + $urandom_range(0, 3)), 1'b0);
    else
      queue_req(FUNC_ACK, SEQ_W'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(chk_st, idx, data);
    apply_reg(gen_st, idx, data);
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] to,
                                input logic [CFG_DATA_W-1:0] iv,
                                input logic [CFG_DATA_W-1:0] pk);
    write_reg(CFG_WINDOW, w);
    write_reg(CFG_TIMEOUT, to);
    write_reg(CFG_INTERVAL, iv);
    write_reg(CFG_PACKET, pk);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(window_step(chk_st, offered));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          offered = pending_reqs.pop_front();
          func <= offered.func;
          ack_expected_seq <= offered.ack_seq;
          ack_bit_error <= offered.ack_err;
          in_valid <= 1'b1;
          send_gap <= draw_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, with one long hold-off so the unit backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_pause <= 0;
    end else if (out_valid && out_ready) begin
      check_result();
      n_results++;
      pause_len = (n_results == HOLD_AT) ? HOLD_LEN : draw_pause();
      recv_pause <= pause_len;
      out_ready <= (pause_len == 0);
    end else if (recv_pause != 0) begin
      recv_pause <= recv_pause - 1;
      out_ready <= (recv_pause == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL go_back_n_arq_sender_unit");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    n_results = 0;
    n_errors = 0;
    stalled_cycles = 0;
    quiet = 1'b0;
    chk_st = '0;
    chk_st.window = WINDOW_RST;
    chk_st.timeout = TIMEOUT_RST;
    chk_st.interval = INTERVAL_RST;
    chk_st.pkt_bits = PACKET_RST;
    chk_st.send_armed = 1'b1;
    gen_st = chk_st;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first send, corrupted ack, reject, acks outside the window, slide
    queue_req(FUNC_TICK, '0, 1'b0);
    queue_req(FUNC_ACK, gen_st.base, 1'b1);
    queue_req(FUNC_ACK, gen_st.base, 1'b0);
    queue_req(FUNC_ACK, SEQ_W'(gen_st.base + 9), 1'b0);
    queue_req(FUNC_ACK, 16'h8000, 1'b0);
    queue_req(FUNC_ACK, 16'hFFFF, 1'b1);
    queue_req(FUNC_ACK, SEQ_W'(gen_st.base + 1), 1'b0);
    wait_drained();

    // small window: pacing, window full, slide with rearm, timeout go-back
    write_settings(2, 4, 1, 16);
    repeat (13) queue_req(FUNC_TICK, 16'hFFFF, 1'b1);
    queue_req(FUNC_ACK, SEQ_W'(gen_st.base + 1), 1'b0);
    repeat (3) queue_req(FUNC_TICK, '0, 1'b0);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: write_settings(8, 40, 3, 1024);
        1: write_settings(1, 0, 0, 8);
        2: write_settings(0, 3, 1, 0);
        3: write_settings(127, 80, 1, 32'hFFFF);
        4: write_settings(64, 32'hFFFF_FFFF, 32'hFFFF, 1);
        5: write_settings(64, 30, 0, 12000);
        default: write_settings($urandom_range(0, 127), $urandom_range(0, 50),
                                $urandom_range(0, 5), $urandom);
      endcase
      quiet = (p % 3 == 1);
      repeat (PHASE_REQS) queue_random_req();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report($sformatf("%0d results never arrived", expected_results.size()));
    if (n_errors == 0) begin
      $display("PASS go_back_n_arq_sender_unit");
    end else begin
      $display("FAIL go_back_n_arq_sender_unit");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gbn_pkg.sv
rtl/go_back_n_arq_sender_unit.sv
tb/tb.sv
